@@ rtl/jpq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job priority queue package
// Shared request codes, status codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package jpq_pkg;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned PAGES_W = 16;
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

   localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

@@ rtl/jpq_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job priority queue controller
// Sequences request acceptance, the id scan and the response register.
// ---------------------------------------------------------------------------
module jpq_ctrl
   import jpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      dp_cmd.accept    = req_valid && (state_ff == ST_IDLE);
      dp_cmd.scan_step = (state_ff == ST_BUSY) && !dp_status.scan_done;
      dp_cmd.rsp_load  = (state_ff == ST_BUSY) && dp_status.scan_done &&
                         (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (dp_cmd.accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (dp_cmd.rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_only_busy: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rsp_load |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("response load did not return to idle with a valid response");

   a_no_step_on_load: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.scan_step && dp_cmd.rsp_load))
      else $error("scan step and response load in the same cycle");

   a_accept_starts_busy: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accept |=> (state_ff == ST_BUSY))
      else $error("accepted request did not start processing");
`endif

endmodule

@@ rtl/jpq_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job priority queue datapath
// Sorted slot registers with per-slot insert logic, id scan and response regs.
// ---------------------------------------------------------------------------
module jpq_datapath
   import jpq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         dp_cmd,
   output dp_status_type      dp_status,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [ID_W-1:0]    req_job_id,
   input  logic [PAGES_W-1:0] req_job_pages,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ID_W-1:0]    rsp_popped_id,
   output logic [PAGES_W-1:0] rsp_popped_pages,
   output logic [COUNT_W-1:0] rsp_entry_count,
   output logic [ID_W-1:0]    rsp_next_id
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ID_W-1:0]    slot_id_ff    [QUEUE_DEPTH];
   logic [ID_W-1:0]    slot_id_in    [QUEUE_DEPTH];
   logic [PAGES_W-1:0] slot_pages_ff [QUEUE_DEPTH];
   logic [PAGES_W-1:0] slot_pages_in [QUEUE_DEPTH];
   logic [ID_W-1:0]    scan_ff       [QUEUE_DEPTH];
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [ID_W-1:0]    max_ff;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [ID_W-1:0]    res_pid_ff, res_pid_in;
   logic [PAGES_W-1:0] res_pages_ff, res_pages_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]    rsp_pid_ff;
   logic [PAGES_W-1:0] rsp_pages_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [ID_W-1:0]    rsp_next_ff;
   logic [ID_W-1:0]    next_id;
   logic [QUEUE_DEPTH-1:0] eff;
   logic               is_empty, is_full;

   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      eff[0] = is_empty || (req_job_pages >= slot_pages_ff[0]);
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         eff[i] = eff[0] || (CNT_W'(i) >= occ_ff) || (slot_pages_ff[i] < req_job_pages);
      end
   end

   always_comb begin
      slot_id_in    = slot_id_ff;
      slot_pages_in = slot_pages_ff;
      occ_in        = occ_ff;
      res_status_in = STAT_OK;
      res_pid_in    = '0;
      res_pages_in  = '0;
      case (req_command)
         CMD_PUSH: begin
            if (is_full) begin
               res_status_in = STAT_PUSH_FULL;
            end else begin
               occ_in = occ_ff + 1'b1;
               if (eff[0]) begin
                  slot_id_in[0]    = req_job_id;
                  slot_pages_in[0] = req_job_pages;
               end
               for (int i = 1; i < QUEUE_DEPTH; i++) begin
                  if (eff[i]) begin
                     if (!eff[i-1]) begin
                        slot_id_in[i]    = req_job_id;
                        slot_pages_in[i] = req_job_pages;
                     end else begin
                        slot_id_in[i]    = slot_id_ff[i-1];
                        slot_pages_in[i] = slot_pages_ff[i-1];
                     end
                  end
               end
            end
         end
         CMD_POP: begin
            if (is_empty) begin
               res_status_in = STAT_POP_EMPTY;
            end else begin
               res_pid_in   = slot_id_ff[0];
               res_pages_in = slot_pages_ff[0];
               occ_in       = occ_ff - 1'b1;
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  slot_id_in[i]    = slot_id_ff[i+1];
                  slot_pages_in[i] = slot_pages_ff[i+1];
               end
            end
         end
         CMD_CLEAR: begin
            occ_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         cnt_ff <= '0;
      end else if (dp_cmd.accept) begin
         occ_ff <= occ_in;
         cnt_ff <= occ_in;
      end else if (dp_cmd.scan_step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         slot_id_ff    <= slot_id_in;
         slot_pages_ff <= slot_pages_in;
         res_status_ff <= res_status_in;
         res_pid_ff    <= res_pid_in;
         res_pages_ff  <= res_pages_in;
         max_ff        <= '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            scan_ff[i] <= (CNT_W'(i) < occ_in) ? slot_id_in[i] : '0;
         end
      end else if (dp_cmd.scan_step) begin
         if (scan_ff[0] > max_ff) begin
            max_ff <= scan_ff[0];
         end
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            scan_ff[i] <= scan_ff[i+1];
         end
         scan_ff[QUEUE_DEPTH-1] <= '0;
      end
   end

   always_comb begin
      if (max_ff == '0) begin
         next_id = ID_W'(1);
      end else if (max_ff == ID_MAX) begin
         next_id = ID_MAX;
      end else begin
         next_id = max_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pid_ff    <= res_pid_ff;
         rsp_pages_ff  <= res_pages_ff;
         rsp_count_ff  <= COUNT_W'(occ_ff);
         rsp_next_ff   <= next_id;
      end
   end

   assign dp_status.scan_done = (cnt_ff == '0);
   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_id       = rsp_pid_ff;
   assign rsp_popped_pages    = rsp_pages_ff;
   assign rsp_entry_count     = rsp_count_ff;
   assign rsp_next_id         = rsp_next_ff;

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (occ_ff <= CNT_W'(QUEUE_DEPTH)) && (cnt_ff <= occ_ff))
      else $error("occupancy or scan count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accept && (req_command == CMD_PUSH) && !is_full
      |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("successful push did not grow the queue");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.accept && (req_command == CMD_POP) && is_empty
      |=> (res_status_ff == STAT_POP_EMPTY) && (occ_ff == '0))
      else $error("pop on empty queue not reported");

   a_head_order: assert property (@(posedge clock) disable iff (reset)
      (occ_ff >= CNT_W'(2)) |-> (slot_pages_ff[0] >= slot_pages_ff[1]))
      else $error("queue head out of order");
`endif

endmodule

@@ rtl/job_priority_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job priority queue
// Sorted queue of jobs (id, page count) held in descending page order.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one request: push, pop or clear, with the job
//   id and page count used by a push. The rsp_ channel returns one response
//   per request: status, the popped job, the entry count after the request
//   and the next free id (largest stored id plus one, saturating).
//   A request is taken when req_valid is high and req_stall is low; the
//   response moves when rsp_valid is high and rsp_stall is low.
//   A request updates the slot registers when it is taken, then the stored
//   ids are scanned one per cycle to find the largest id, and the response
//   register is loaded once the scan is done and that register is free.
//   The next request is taken while the last response still waits.
//   When rsp_stall is held, the finished response waits in its register.
//   The request after it is still taken and processed, then holds until
//   that register frees, and further requests are stalled meanwhile.
//   Reset empties the queue and drops any pending response.
// ---------------------------------------------------------------------------
module job_priority_queue
   import jpq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [ID_W-1:0]    req_job_id,
   input  logic [PAGES_W-1:0] req_job_pages,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ID_W-1:0]    rsp_popped_id,
   output logic [PAGES_W-1:0] rsp_popped_pages,
   output logic [COUNT_W-1:0] rsp_entry_count,
   output logic [ID_W-1:0]    rsp_next_id
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   jpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   jpq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_command      (req_command),
      .req_job_id       (req_job_id),
      .req_job_pages    (req_job_pages),
      .rsp_status       (rsp_status),
      .rsp_popped_id    (rsp_popped_id),
      .rsp_popped_pages (rsp_popped_pages),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_next_id      (rsp_next_id)
   );

endmodule

@@ tb/tb_job_priority_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Job priority queue testbench
// Drives push, pop and clear requests through the request channel with random
// gaps and response stalls, predicts every response from a shadow copy of the
// sorted queue and compares each response field against that prediction.
// ---------------------------------------------------------------------------
module tb_job_priority_queue
   import jpq_pkg::*;
();

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TAIL_ITEMS = 150;
   localparam int HOLD_AT_REPLY = 400;
   localparam int HOLD_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1100;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ID_W-1:0]    job_id;
      logic [PAGES_W-1:0] job_pages;
   } job_request_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [ID_W-1:0]    popped_id;
      logic [PAGES_W-1:0] popped_pages;
      logic [COUNT_W-1:0] entry_count;
      logic [ID_W-1:0]    next_id;
   } queue_reply_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_command = CMD_PUSH;
   logic [ID_W-1:0]    req_job_id = '0;
   logic [PAGES_W-1:0] req_job_pages = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [STAT_W-1:0]  rsp_status;
   logic [ID_W-1:0]    rsp_popped_id;
   logic [PAGES_W-1:0] rsp_popped_pages;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic [ID_W-1:0]    rsp_next_id;

   job_request_type pending_requests[$];
   queue_reply_type expected_replies[$];
   job_request_type current_req;
   queue_reply_type want;

   logic [ID_W-1:0]    shadow_id[QUEUE_DEPTH];
   logic [PAGES_W-1:0] shadow_pages[QUEUE_DEPTH];
   int                 shadow_count = 0;

   bit failed = 1'b0;
   bit held_off = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int replies_seen = 0;

   job_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_job_id(req_job_id),
      .req_job_pages(req_job_pages),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_popped_id(rsp_popped_id),
      .rsp_popped_pages(rsp_popped_pages),
      .rsp_entry_count(rsp_entry_count),
      .rsp_next_id(rsp_next_id)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one request to the shadow queue and returns the response it owes.
   function automatic queue_reply_type apply_request(job_request_type r);
      queue_reply_type rep;
      int              pos;
      int              i;
      logic [ID_W-1:0] top;
      rep = '0;
      case (r.command)
         CMD_PUSH: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               rep.status = STAT_PUSH_FULL;
            end else begin
               if (shadow_count == 0 || r.job_pages >= shadow_pages[0]) begin
                  pos = 0;
               end else begin
                  pos = 1;
                  while (pos < shadow_count && shadow_pages[pos] >= r.job_pages)
                     pos++;
               end
               for (i = shadow_count; i > pos; i--) begin
                  shadow_id[i] = shadow_id[i-1];
                  shadow_pages[i] = shadow_pages[i-1];
               end
               shadow_id[pos] = r.job_id;
               shadow_pages[pos] = r.job_pages;
               shadow_count++;
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) begin
               rep.status = STAT_POP_EMPTY;
            end else begin
               rep.popped_id = shadow_id[0];
               rep.popped_pages = shadow_pages[0];
               for (i = 0; i + 1 < shadow_count; i++) begin
                  shadow_id[i] = shadow_id[i+1];
                  shadow_pages[i] = shadow_pages[i+1];
               end
               shadow_count--;
            end
         end
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      top = '0;
      for (i = 0; i < shadow_count; i++)
         if (shadow_id[i] > top) top = shadow_id[i];
      rep.entry_count = COUNT_W'(shadow_count);
      if (top == '0) rep.next_id = ID_W'(1);
      else if (top == ID_MAX) rep.next_id = ID_MAX;
      else rep.next_id = top + 1'b1;
      return rep;
   endfunction

   function automatic logic [PAGES_W-1:0] pick_pages();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return PAGES_W'($urandom_range(0, 7));
      else if (roll < 8) return PAGES_W'($urandom_range(0, 65535));
      else if (roll == 8) return '0;
      else return '1;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return ID_W'($urandom_range(0, 65535));
      else if (roll < 8) return ID_W'($urandom_range(0, 20));
      else if (roll == 8) return '0;
      else return ID_MAX;
   endfunction

   task automatic queue_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                logic [PAGES_W-1:0] pages);
      job_request_type r;
      r.command = cmd;
      r.job_id = id;
      r.job_pages = pages;
      pending_requests.push_back(r);
   endtask

   task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         failed = 1'b1;
      end
   endtask

   // Driver: offers the next pending request and updates the prediction
   // whenever a request is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_replies.push_back(apply_request(current_req));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() >= TAIL_ITEMS && hold_left == 0 &&
                         $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               current_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_command <= current_req.command;
               req_job_id <= current_req.job_id;
               req_job_pages <= current_req.job_pages;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response and drives the response stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: response with none expected, actual status %0d id %0d",
                        $time, rsp_status, rsp_popped_id);
               failed = 1'b1;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("popped_id", want.popped_id, rsp_popped_id);
               check_field("popped_pages", want.popped_pages, rsp_popped_pages);
               check_field("entry_count", 16'(want.entry_count), 16'(rsp_entry_count));
               check_field("next_id", want.next_id, rsp_next_id);
            end
            replies_seen++;
         end
         if (!held_off && replies_seen >= HOLD_AT_REPLY) begin
            held_off = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (pending_requests.size() >= TAIL_ITEMS &&
                      $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int made;
      int run_left;
      int push_pct;
      int roll;
      int i;

      queue_request(CMD_POP, 16'd9, 16'd9);
      queue_request(CMD_CLEAR, 16'd0, 16'd0);
      queue_request(CMD_UNUSED, 16'hA5A5, 16'h5A5A);
      queue_request(CMD_PUSH, 16'd0, 16'd0);
      queue_request(CMD_POP, 16'd0, 16'd0);
      queue_request(CMD_PUSH, ID_MAX, 16'hFFFF);
      queue_request(CMD_PUSH, 16'd5, 16'd100);
      queue_request(CMD_PUSH, 16'd6, 16'd100);
      queue_request(CMD_PUSH, 16'd7, 16'hFFFF);
      for (i = 0; i < QUEUE_DEPTH - 4; i++)
         queue_request(CMD_PUSH, pick_id(), pick_pages());
      queue_request(CMD_PUSH, 16'd1234, 16'hFFFF);
      queue_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
      queue_request(CMD_POP, 16'd0, 16'd0);
      queue_request(CMD_CLEAR, 16'd0, 16'd0);

      // Random phases, each with its own random push share, fill or drain the queue.
      made = 0;
      run_left = 0;
      push_pct = 50;
      while (made < RANDOM_ITEMS) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 60);
            push_pct = $urandom_range(15, 85);
         end
         run_left--;
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            queue_request(CMD_CLEAR, pick_id(), pick_pages());
            made++;
         end else if (roll < 4) begin
            queue_request(CMD_UNUSED, pick_id(), pick_pages());
         end else if ($urandom_range(0, 99) < push_pct) begin
            queue_request(CMD_PUSH, pick_id(), pick_pages());
            made++;
         end else begin
            queue_request(CMD_POP, pick_id(), pick_pages());
            made++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
      while (expected_replies.size() > 0) @(posedge clock);
      repeat (QUEUE_DEPTH + 4) @(posedge clock);
      if (expected_replies.size() > 0) failed = 1'b1;

      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
